>>> hdl/gvc_pkg.sv
// ----------------------------------------------------------------------------
// gvc_pkg
// shared types and constants for the gamepad velocity command block
// ----------------------------------------------------------------------------
package gvc_pkg;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_W     = 7;
   localparam int VEL_W      = 16;
   localparam int PC_W       = 4;
   localparam int UCODE_LEN  = 15;
   localparam int MUL_W      = 30;
   localparam int PROD_W     = 60;
   localparam int X_W        = 29;
   localparam int Q_W        = 15;

   localparam logic [7:0] STATUS_OK = 8'h5A;

   localparam int BTN_START = 3;
   localparam int BTN_L2    = 8;
   localparam int BTN_R2    = 9;
   localparam int BTN_L1    = 10;
   localparam int BTN_R1    = 11;

   localparam logic [CSR_ADDR_W-1:0] REG_FWD_MIN  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FWD_MAX  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SIDE_MIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SIDE_MAX = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TURN_MIN = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_TURN_MAX = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLDOFF  = 3'd6;

   localparam logic [7:0]  STICK_CENTER = 8'd128;
   localparam logic [6:0]  DEADZONE_MAG = 7'd10;
   localparam logic [13:0] AXIS_SCALE   = 14'd100;
   localparam logic [13:0] AXIS_OFFSET  = 14'd1016;

   // round(a * g * 128 / 14605) as floor((256 * a * g + 14605) / 29210)
   localparam int RECIP_SHIFT = 44;
   localparam logic [Q_W-1:0] ROUND_DIV  = 15'd29210;
   localparam logic [X_W-1:0] ROUND_BIAS = 29'd14605;
   localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd29210;
   localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_GAIN,
      OP_MUL_AG,
      OP_MUL_RECIP,
      OP_MUL_BACK,
      OP_FIX,
      OP_DONE
   } op_type;

   typedef enum logic [1:0] {
      AX_FWD,
      AX_SIDE,
      AX_TURN
   } axis_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_START,
      COND_DEAD
   } cond_type;

   typedef struct packed {
      op_type          op;
      axis_type        axis;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   localparam ucode_type UCODE [UCODE_LEN] = '{
      '{OP_NOP,       AX_FWD,  COND_START, 4'd14},
      '{OP_GAIN,      AX_FWD,  COND_NONE,  4'd0},
      '{OP_MUL_AG,    AX_FWD,  COND_DEAD,  4'd6},
      '{OP_MUL_RECIP, AX_FWD,  COND_NONE,  4'd0},
      '{OP_MUL_BACK,  AX_FWD,  COND_NONE,  4'd0},
      '{OP_FIX,       AX_FWD,  COND_NONE,  4'd0},
      '{OP_MUL_AG,    AX_SIDE, COND_DEAD,  4'd10},
      '{OP_MUL_RECIP, AX_SIDE, COND_NONE,  4'd0},
      '{OP_MUL_BACK,  AX_SIDE, COND_NONE,  4'd0},
      '{OP_FIX,       AX_SIDE, COND_NONE,  4'd0},
      '{OP_MUL_AG,    AX_TURN, COND_DEAD,  4'd14},
      '{OP_MUL_RECIP, AX_TURN, COND_NONE,  4'd0},
      '{OP_MUL_BACK,  AX_TURN, COND_NONE,  4'd0},
      '{OP_FIX,       AX_TURN, COND_NONE,  4'd0},
      '{OP_DONE,      AX_FWD,  COND_NONE,  4'd0}
   };

endpackage

>>> hdl/gamepad_velocity_command_top.sv
// ----------------------------------------------------------------------------
// gamepad_velocity_command_top
// turns gamepad poll replies into signed Q5.10 velocity commands
// ----------------------------------------------------------------------------
// Each accepted word is one poll reply plus a tick time; each gives exactly one
// result word. A small microcode program drives one shared 30x30 multiplier:
// a check for START, a gain step, then four steps per stick axis (gain
// multiply, reciprocal multiply, back multiply, rounding fix). An axis in its
// deadzone skips its reciprocal multiply, back multiply and rounding fix and
// keeps a zero velocity, and a held START jumps from the check straight to the
// end. No new word is taken while the program runs; its last step waits
// until the output register is free. That register lets the next reply
// enter while a result still waits to be taken.
module gamepad_velocity_command_top #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // status_byte, button_bits, right_stick_x, left_stick_x, left_stick_y, now_tick
   input  logic [gvc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vel_forward, vel_side, vel_turn, reset_request, rumble_request, reply_valid
   output logic [gvc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [gvc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gvc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int GW = gvc_pkg::GAIN_W;

   // configuration
   logic [GW-1:0] fwd_min_ff, fwd_max_ff, side_min_ff, side_max_ff;
   logic [GW-1:0] turn_min_ff, turn_max_ff;
   logic [15:0]   holdoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_min_ff  <= 7'd0;
         fwd_max_ff  <= 7'd20;
         side_min_ff <= 7'd0;
         side_max_ff <= 7'd20;
         turn_min_ff <= 7'd0;
         turn_max_ff <= 7'd20;
         holdoff_ff  <= 16'd300;
      end else if (csr_we) begin
         case (csr_addr)
            gvc_pkg::REG_FWD_MIN:  fwd_min_ff  <= csr_wdata[GW-1:0];
            gvc_pkg::REG_FWD_MAX:  fwd_max_ff  <= csr_wdata[GW-1:0];
            gvc_pkg::REG_SIDE_MIN: side_min_ff <= csr_wdata[GW-1:0];
            gvc_pkg::REG_SIDE_MAX: side_max_ff <= csr_wdata[GW-1:0];
            gvc_pkg::REG_TURN_MIN: turn_min_ff <= csr_wdata[GW-1:0];
            gvc_pkg::REG_TURN_MAX: turn_max_ff <= csr_wdata[GW-1:0];
            gvc_pkg::REG_HOLDOFF:  holdoff_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state
   gvc_pkg::state_type            state_ff, state_in;
   logic [gvc_pkg::PC_W-1:0]      pc_ff, pc_in;
   gvc_pkg::ucode_type            uc;

   // held reply and gains
   logic [15:0]   buttons_ff;
   logic [7:0]    lx_ff, ly_ff, rx_ff;
   logic [GW-1:0] gain_fwd_ff, gain_side_ff, gain_turn_ff;
   logic [GW-1:0] gain_fwd_in, gain_side_in, gain_turn_in;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [TIME_WIDTH-1:0] last_ff [4];
   logic [3:0]    step_en;

   // datapath
   logic [gvc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [gvc_pkg::X_W-1:0]    x_ff, x_in;
   logic [gvc_pkg::Q_W-1:0]    q_ff;
   logic [gvc_pkg::VEL_W-1:0]  vel_fwd_ff, vel_side_ff, vel_turn_ff, vel_in;
   logic                       valid_ff, rumble_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [gvc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic req_fire, out_free, start_held, cond_hit, done_go;
   logic [7:0]  ax_byte;
   logic [GW-1:0] ax_gain;
   logic [6:0]  ax_mag;
   logic        ax_pos, ax_dead;
   logic [13:0] ax_scaled;
   logic [gvc_pkg::MUL_W-1:0] mul_a, mul_b;
   logic [gvc_pkg::Q_W-1:0]   q_est;
   logic [gvc_pkg::X_W-1:0]   rem;
   logic [gvc_pkg::Q_W-1:0]   q_fix;

   assign uc         = gvc_pkg::UCODE[pc_ff];
   assign req_tready = (state_ff == gvc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign start_held = !buttons_ff[gvc_pkg::BTN_START];
   assign done_go    = (state_ff == gvc_pkg::ST_RUN) && (uc.op == gvc_pkg::OP_DONE) && out_free;

   // axis operand selection
   always_comb begin
      case (uc.axis)
         gvc_pkg::AX_FWD:  begin ax_byte = ly_ff; ax_gain = gain_fwd_ff;  end
         gvc_pkg::AX_SIDE: begin ax_byte = lx_ff; ax_gain = gain_side_ff; end
         gvc_pkg::AX_TURN: begin ax_byte = rx_ff; ax_gain = gain_turn_ff; end
         default:          begin ax_byte = rx_ff; ax_gain = gain_turn_ff; end
      endcase
      ax_pos = ax_byte > gvc_pkg::STICK_CENTER;
      if (ax_byte >= gvc_pkg::STICK_CENTER) begin
         ax_mag = 7'(ax_byte - gvc_pkg::STICK_CENTER);
      end else if (ax_byte == 8'd0) begin
         ax_mag = 7'd127;
      end else begin
         ax_mag = 7'(gvc_pkg::STICK_CENTER - ax_byte);
      end
      ax_dead   = ax_mag <= gvc_pkg::DEADZONE_MAG;
      ax_scaled = 14'({7'd0, ax_mag} * gvc_pkg::AXIS_SCALE) - gvc_pkg::AXIS_OFFSET;
   end

   // jump conditions
   always_comb begin
      case (uc.cond)
         gvc_pkg::COND_START: cond_hit = start_held;
         gvc_pkg::COND_DEAD:  cond_hit = ax_dead;
         default:             cond_hit = 1'b0;
      endcase
   end

   // shared multiplier and rounding fix
   assign q_est = prod_ff[gvc_pkg::RECIP_SHIFT +: gvc_pkg::Q_W];
   assign rem   = x_ff - prod_ff[gvc_pkg::X_W-1:0];
   assign q_fix = (rem >= gvc_pkg::X_W'(gvc_pkg::ROUND_DIV)) ? q_ff + 15'd1 : q_ff;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      x_in   = x_ff;
      vel_in = {1'b0, q_fix};
      if (ax_pos) begin
         vel_in = 16'(16'd0 - {1'b0, q_fix});
      end
      case (uc.op)
         gvc_pkg::OP_MUL_AG: begin
            mul_a = gvc_pkg::MUL_W'(ax_scaled);
            mul_b = gvc_pkg::MUL_W'(ax_gain);
         end
         gvc_pkg::OP_MUL_RECIP: begin
            x_in  = {prod_ff[20:0], 8'd0} + gvc_pkg::ROUND_BIAS;
            mul_a = gvc_pkg::MUL_W'(x_in);
            mul_b = gvc_pkg::RECIP;
         end
         gvc_pkg::OP_MUL_BACK: begin
            mul_a = gvc_pkg::MUL_W'(q_est);
            mul_b = gvc_pkg::MUL_W'(gvc_pkg::ROUND_DIV);
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // gain stepping with hold-off and clamping
   always_comb begin
      logic l1, l2, r1, r2;
      logic [TIME_WIDTH-1:0] gap;
      logic signed [8:0] gf, gs, gt;
      l1 = !buttons_ff[gvc_pkg::BTN_L1];
      l2 = !buttons_ff[gvc_pkg::BTN_L2];
      r1 = !buttons_ff[gvc_pkg::BTN_R1];
      r2 = !buttons_ff[gvc_pkg::BTN_R2];
      for (int s = 0; s < 4; s++) begin
         gap        = now_ff - last_ff[s];
         step_en[s] = gap > TIME_WIDTH'(holdoff_ff);
      end
      step_en[0] = step_en[0] && l1 && !l2;
      step_en[1] = step_en[1] && l2 && !l1;
      step_en[2] = step_en[2] && r1 && !r2;
      step_en[3] = step_en[3] && r2 && !r1;
      gf = $signed({2'b00, gain_fwd_ff})  + $signed({8'd0, step_en[0]})
           - $signed({8'd0, step_en[1]});
      gs = $signed({2'b00, gain_side_ff}) + $signed({8'd0, step_en[0]})
           - $signed({8'd0, step_en[1]});
      gt = $signed({2'b00, gain_turn_ff}) + $signed({8'd0, step_en[2]})
           - $signed({8'd0, step_en[3]});
      if (gf < $signed({2'b00, fwd_min_ff})) gf = $signed({2'b00, fwd_min_ff});
      else if (gf > $signed({2'b00, fwd_max_ff})) gf = $signed({2'b00, fwd_max_ff});
      if (gs < $signed({2'b00, side_min_ff})) gs = $signed({2'b00, side_min_ff});
      else if (gs > $signed({2'b00, side_max_ff})) gs = $signed({2'b00, side_max_ff});
      if (gt < $signed({2'b00, turn_min_ff})) gt = $signed({2'b00, turn_min_ff});
      else if (gt > $signed({2'b00, turn_max_ff})) gt = $signed({2'b00, turn_max_ff});
      gain_fwd_in  = gf[GW-1:0];
      gain_side_in = gs[GW-1:0];
      gain_turn_in = gt[GW-1:0];
   end

   // step counter
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         gvc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = gvc_pkg::ST_RUN;
               pc_in    = '0;
            end
         end
         gvc_pkg::ST_RUN: begin
            if (uc.op == gvc_pkg::OP_DONE) begin
               if (out_free) state_in = gvc_pkg::ST_IDLE;
            end else if (cond_hit) begin
               pc_in = uc.target;
            end else begin
               pc_in = pc_ff + 4'd1;
            end
         end
         default: state_in = gvc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gvc_pkg::ST_IDLE;
         pc_ff        <= '0;
         buttons_ff   <= 16'hFFFF;
         lx_ff        <= gvc_pkg::STICK_CENTER;
         ly_ff        <= gvc_pkg::STICK_CENTER;
         rx_ff        <= gvc_pkg::STICK_CENTER;
         gain_fwd_ff  <= 7'd5;
         gain_side_ff <= 7'd5;
         gain_turn_ff <= 7'd5;
         for (int s = 0; s < 4; s++) last_ff[s] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (req_fire && req_tdata[7:0] == gvc_pkg::STATUS_OK) begin
            buttons_ff <= req_tdata[23:8];
            rx_ff      <= req_tdata[31:24];
            lx_ff      <= req_tdata[39:32];
            ly_ff      <= req_tdata[47:40];
         end
         if (state_ff == gvc_pkg::ST_RUN && uc.op == gvc_pkg::OP_GAIN) begin
            gain_fwd_ff  <= gain_fwd_in;
            gain_side_ff <= gain_side_in;
            gain_turn_ff <= gain_turn_in;
            for (int s = 0; s < 4; s++) begin
               if (step_en[s]) last_ff[s] <= now_ff;
            end
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff      <= TIME_WIDTH'(req_tdata[79:48]);
         valid_ff    <= req_tdata[7:0] == gvc_pkg::STATUS_OK;
         rumble_ff   <= 1'b0;
         vel_fwd_ff  <= '0;
         vel_side_ff <= '0;
         vel_turn_ff <= '0;
      end
      if (state_ff == gvc_pkg::ST_RUN) begin
         prod_ff <= prod_in;
         x_ff    <= x_in;
         if (uc.op == gvc_pkg::OP_MUL_BACK) q_ff <= q_est;
         if (uc.op == gvc_pkg::OP_GAIN) rumble_ff <= |step_en;
         if (uc.op == gvc_pkg::OP_FIX) begin
            case (uc.axis)
               gvc_pkg::AX_FWD:  vel_fwd_ff  <= vel_in;
               gvc_pkg::AX_SIDE: vel_side_ff <= vel_in;
               default:          vel_turn_ff <= vel_in;
            endcase
         end
      end
      if (done_go) begin
         rsp_data_ff <= {5'd0, valid_ff, rumble_ff, start_held,
                         vel_turn_ff, vel_side_ff, vel_fwd_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_reset_zero_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[47:0] == 48'd0)
      else $error("reset request with nonzero speed");

   a_reset_no_rumble: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[48] && rsp_tdata[49]))
      else $error("reset request together with rumble");

   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == gvc_pkg::ST_RUN && pc_ff == '0)
      else $error("accepted word did not start the program");

   a_done_loads_output: assert property (@(posedge clock) disable iff (reset)
      done_go |=> rsp_valid_ff && state_ff == gvc_pkg::ST_IDLE)
      else $error("finished item not loaded into output register");

   a_gain_only_in_step: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == gvc_pkg::ST_RUN && uc.op == gvc_pkg::OP_GAIN)
      |=> $stable(gain_fwd_ff) && $stable(gain_turn_ff))
      else $error("gain changed outside the gain step");

endmodule

>>> sim/gamepad_velocity_command_top_tb.sv
// ----------------------------------------------------------------------------
// gamepad_velocity_command_top_tb
// self-checking bench for the gamepad velocity command block
// ----------------------------------------------------------------------------
// Poll replies go in on the req stream and velocity commands are checked on
// the rsp stream. A behavioral model of the block keeps its own copy of the
// held buttons, sticks, gains, step times and limit registers, and predicts
// one command word per accepted reply. Directed replies cover the stick
// extremes, the deadzone edges, invalid status bytes, START, every shoulder
// button alone and in pairs, the hold-off edge and tick wrap. Then come
// limit register extremes and random traffic under random stalls on both
// sides.
// ----------------------------------------------------------------------------
module gamepad_velocity_command_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] now_tick;
      logic [7:0]  left_stick_y;
      logic [7:0]  left_stick_x;
      logic [7:0]  right_stick_x;
      logic [15:0] button_bits;
      logic [7:0]  status_byte;
   } poll_reply_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic        reply_valid;
      logic        rumble_request;
      logic        reset_request;
      logic [15:0] vel_turn;
      logic [15:0] vel_side;
      logic [15:0] vel_forward;
   } velocity_cmd_type;

   localparam logic [15:0] NO_BUTTONS = 16'hFFFF;
   localparam logic [15:0] HOLD_START = ~(16'd1 << gvc_pkg::BTN_START);
   localparam logic [15:0] HOLD_L1    = ~(16'd1 << gvc_pkg::BTN_L1);
   localparam logic [15:0] HOLD_L2    = ~(16'd1 << gvc_pkg::BTN_L2);
   localparam logic [15:0] HOLD_R1    = ~(16'd1 << gvc_pkg::BTN_R1);
   localparam logic [15:0] HOLD_R2    = ~(16'd1 << gvc_pkg::BTN_R2);

   localparam logic [gvc_pkg::CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;

   localparam int SLOT_L1 = 0;
   localparam int SLOT_L2 = 1;
   localparam int SLOT_R1 = 2;
   localparam int SLOT_R2 = 3;

   localparam longint AXIS_DEN       = 116840;
   localparam int     IDLE_PCT       = 34;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     SETTLE_CYCLES  = 32;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic [gvc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [gvc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_we     = 1'b0;
   logic [gvc_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [gvc_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   gamepad_velocity_command_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // model state
   logic [15:0] limit_reg [0:6];
   logic [15:0] held_buttons;
   logic [7:0]  held_left_x;
   logic [7:0]  held_left_y;
   logic [7:0]  held_right_x;
   int          gain_forward;
   int          gain_side;
   int          gain_turn;
   logic [31:0] last_step_tick [0:3];

   velocity_cmd_type expected_commands [$];
   logic [31:0]   tick_now;
   bit            steady_flow = 1'b0;
   int            mismatches  = 0;
   int            stall_cycles = 0;

   function automatic void clear_command_state();
      limit_reg[gvc_pkg::REG_FWD_MIN]  = 16'd0;
      limit_reg[gvc_pkg::REG_FWD_MAX]  = 16'd20;
      limit_reg[gvc_pkg::REG_SIDE_MIN] = 16'd0;
      limit_reg[gvc_pkg::REG_SIDE_MAX] = 16'd20;
      limit_reg[gvc_pkg::REG_TURN_MIN] = 16'd0;
      limit_reg[gvc_pkg::REG_TURN_MAX] = 16'd20;
      limit_reg[gvc_pkg::REG_HOLDOFF]  = 16'd300;
      held_buttons = NO_BUTTONS;
      held_left_x  = gvc_pkg::STICK_CENTER;
      held_left_y  = gvc_pkg::STICK_CENTER;
      held_right_x = gvc_pkg::STICK_CENTER;
      gain_forward = 5;
      gain_side    = 5;
      gain_turn    = 5;
      for (int i = 0; i < 4; i++) last_step_tick[i] = 32'd0;
   endfunction

   function automatic void apply_limit_write(logic [gvc_pkg::CSR_ADDR_W-1:0] idx,
                                             logic [15:0] v);
      if (idx < gvc_pkg::REG_HOLDOFF) begin
         limit_reg[idx] = v & 16'h007F;
      end else if (idx == gvc_pkg::REG_HOLDOFF) begin
         limit_reg[idx] = v;
      end
   endfunction

   function automatic bit button_down(int b);
      return held_buttons[b] == 1'b0;
   endfunction

   function automatic bit step_allowed(int slot, logic [31:0] now);
      logic [31:0] gap;
      gap = now - last_step_tick[slot];
      if (gap > 32'(limit_reg[gvc_pkg::REG_HOLDOFF])) begin
         last_step_tick[slot] = now;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int clamp_gain(int x, logic [15:0] lo, logic [15:0] hi);
      if (x < int'(lo)) return int'(lo);
      if (x > int'(hi)) return int'(hi);
      return x;
   endfunction

   function automatic logic [15:0] scaled_axis(logic [7:0] b, int gain);
      int     d;
      int     mag;
      longint num;
      longint q;
      d = int'(b) - 128;
      if (d < -127) d = -127;
      mag = (d < 0) ? -d : d;
      if (mag <= 10) return 16'd0;
      num = longint'(100 * mag - 1016) * longint'(gain) * 1024;
      q = (num * 2 + AXIS_DEN) / (2 * AXIS_DEN);
      return (d > 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic velocity_cmd_type predict_velocity_command(poll_reply_type p);
      velocity_cmd_type c;
      bit            l1;
      bit            l2;
      bit            r1;
      bit            r2;
      c = '0;
      c.reply_valid = (p.status_byte == gvc_pkg::STATUS_OK);
      if (c.reply_valid) begin
         held_buttons = p.button_bits;
         held_right_x = p.right_stick_x;
         held_left_x  = p.left_stick_x;
         held_left_y  = p.left_stick_y;
      end
      if (button_down(gvc_pkg::BTN_START)) begin
         c.reset_request = 1'b1;
         return c;
      end
      l1 = button_down(gvc_pkg::BTN_L1);
      l2 = button_down(gvc_pkg::BTN_L2);
      r1 = button_down(gvc_pkg::BTN_R1);
      r2 = button_down(gvc_pkg::BTN_R2);
      if (l1 && !l2 && step_allowed(SLOT_L1, p.now_tick)) begin
         gain_forward++;
         gain_side++;
         c.rumble_request = 1'b1;
      end
      if (l2 && !l1 && step_allowed(SLOT_L2, p.now_tick)) begin
         gain_forward--;
         gain_side--;
         c.rumble_request = 1'b1;
      end
      if (r1 && !r2 && step_allowed(SLOT_R1, p.now_tick)) begin
         gain_turn++;
         c.rumble_request = 1'b1;
      end
      if (r2 && !r1 && step_allowed(SLOT_R2, p.now_tick)) begin
         gain_turn--;
         c.rumble_request = 1'b1;
      end
      gain_forward = clamp_gain(gain_forward, limit_reg[gvc_pkg::REG_FWD_MIN],
                                limit_reg[gvc_pkg::REG_FWD_MAX]);
      gain_side = clamp_gain(gain_side, limit_reg[gvc_pkg::REG_SIDE_MIN],
                             limit_reg[gvc_pkg::REG_SIDE_MAX]);
      gain_turn = clamp_gain(gain_turn, limit_reg[gvc_pkg::REG_TURN_MIN],
                             limit_reg[gvc_pkg::REG_TURN_MAX]);
      c.vel_forward = scaled_axis(held_left_y, gain_forward);
      c.vel_side    = scaled_axis(held_left_x, gain_side);
      c.vel_turn    = scaled_axis(held_right_x, gain_turn);
      return c;
   endfunction

   function automatic poll_reply_type make_reply(logic [7:0] st, logic [15:0] btn,
                                                 logic [7:0] rx, logic [7:0] lx,
                                                 logic [7:0] ly, logic [31:0] tick);
      poll_reply_type p;
      p.status_byte   = st;
      p.button_bits   = btn;
      p.right_stick_x = rx;
      p.left_stick_x  = lx;
      p.left_stick_y  = ly;
      p.now_tick      = tick;
      return p;
   endfunction

   function automatic logic [7:0] random_stick();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return ($urandom_range(1) == 0) ? 8'($urandom_range(2)) : 8'($urandom_range(253, 255));
      if (pick < 35) return 8'($urandom_range(115, 141));
      if (pick < 45) return gvc_pkg::STICK_CENTER;
      return 8'($urandom);
   endfunction

   function automatic poll_reply_type random_reply();
      poll_reply_type p;
      int          pick;
      int          holdoff;
      p.status_byte = ($urandom_range(99) < 85) ? gvc_pkg::STATUS_OK : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) begin
         p.button_bits = 16'($urandom);
      end else if (pick < 16) begin
         p.button_bits = HOLD_START & 16'($urandom);
      end else begin
         p.button_bits = NO_BUTTONS;
         if ($urandom_range(99) < 40) p.button_bits &= HOLD_L1;
         if ($urandom_range(99) < 40) p.button_bits &= HOLD_L2;
         if ($urandom_range(99) < 40) p.button_bits &= HOLD_R1;
         if ($urandom_range(99) < 40) p.button_bits &= HOLD_R2;
      end
      p.right_stick_x = random_stick();
      p.left_stick_x  = random_stick();
      p.left_stick_y  = random_stick();
      holdoff = int'(limit_reg[gvc_pkg::REG_HOLDOFF]);
      if ($urandom_range(99) < 5) tick_now = $urandom;
      else tick_now += 32'($urandom_range(0, holdoff + holdoff / 4 + 2));
      p.now_tick = tick_now;
      return p;
   endfunction

   // all driving tasks are entered just after a rising edge
   task automatic send_reply(poll_reply_type p);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      expected_commands.push_back(predict_velocity_command(p));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_commands.size() != 0);
   endtask

   task automatic csr_write(logic [gvc_pkg::CSR_ADDR_W-1:0] idx, logic [15:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      apply_limit_write(idx, v);
   endtask

   task automatic set_gain_limits(logic [15:0] fmin, logic [15:0] fmax, logic [15:0] smin,
                                  logic [15:0] smax, logic [15:0] tmin, logic [15:0] tmax,
                                  logic [15:0] holdoff);
      wait_for_results();
      csr_write(gvc_pkg::REG_FWD_MIN, fmin);
      csr_write(gvc_pkg::REG_FWD_MAX, fmax);
      csr_write(gvc_pkg::REG_SIDE_MIN, smin);
      csr_write(gvc_pkg::REG_SIDE_MAX, smax);
      csr_write(gvc_pkg::REG_TURN_MIN, tmin);
      csr_write(gvc_pkg::REG_TURN_MAX, tmax);
      csr_write(gvc_pkg::REG_HOLDOFF, holdoff);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_replies(int count);
      repeat (count) begin
         if ($urandom_range(49) == 0) wait_for_results();
         send_reply(random_reply());
      end
   endtask

   task automatic test_directed();
      send_reply(make_reply(gvc_pkg::STATUS_OK, NO_BUTTONS, 8'd128, 8'd128, 8'd128, 32'd0));
      send_reply(make_reply(gvc_pkg::STATUS_OK, NO_BUTTONS, 8'd0, 8'd255, 8'd1, 32'd10));
      // deadzone edges on both sides of centre
      send_reply(make_reply(gvc_pkg::STATUS_OK, NO_BUTTONS, 8'd118, 8'd139, 8'd117, 32'd20));
      send_reply(make_reply(gvc_pkg::STATUS_OK, NO_BUTTONS, 8'd138, 8'd255, 8'd0, 32'd30));
      // invalid replies fall back on the held values
      send_reply(make_reply(8'h00, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            32'd40));
      send_reply(make_reply(8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00, 32'd50));
      send_reply(make_reply(8'h5B, HOLD_START, 8'hFF, 8'hFF, 8'hFF, 32'd60));
      // hold-off edge: a gap equal to the hold-off does not step
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L1, 8'd200, 8'd60, 8'd20, 32'd300));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L1, 8'd200, 8'd60, 8'd20, 32'd301));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L1, 8'd200, 8'd60, 8'd20, 32'd302));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L1 & HOLD_L2, 8'd200, 8'd60, 8'd20,
                            32'd5000));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L2, 8'd200, 8'd60, 8'd20, 32'd5000));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_R1, 8'd10, 8'd250, 8'd240, 32'd6000));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_R2, 8'd10, 8'd250, 8'd240, 32'd6100));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_R1 & HOLD_R2, 8'd10, 8'd250, 8'd240,
                            32'd20000));
      // START wins over everything
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_START & HOLD_L1, 8'd0, 8'd0, 8'd0,
                            32'd30000));
      send_reply(make_reply(gvc_pkg::STATUS_OK, 16'h0000, 8'd255, 8'd255, 8'd255, 32'd40000));
      send_reply(make_reply(8'h00, NO_BUTTONS, 8'd128, 8'd128, 8'd128, 32'd50000));
      // tick wrap
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L1, 8'd1, 8'd2, 8'd3, 32'hFFFF_FFFF));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_L1, 8'd1, 8'd2, 8'd3, 32'h0000_0010));
      send_reply(make_reply(gvc_pkg::STATUS_OK, HOLD_R2 & HOLD_L2, 8'd140, 8'd116, 8'd255,
                            32'h8000_0000));
      tick_now = 32'h8000_0000;
      wait_for_results();
   endtask

   task automatic test_limit_extremes();
      set_gain_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_random_replies(30);
      set_gain_limits(16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd1);
      send_random_replies(30);
      // min above max
      set_gain_limits(16'd100, 16'd0, 16'd60, 16'd10, 16'd0, 16'd100, 16'd300);
      send_random_replies(30);
      // wide data is masked to the register width
      set_gain_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_random_replies(30);
      set_gain_limits(16'd0, 16'd100, 16'd0, 16'd100, 16'd0, 16'd100, 16'd0);
      send_random_replies(30);
      wait_for_results();
      csr_write(REG_UNUSED, 16'($urandom));
      csr_we <= 1'b0;
      send_random_replies(30);
   endtask

   function automatic logic [15:0] random_limit();
      return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
   endfunction

   function automatic logic [15:0] random_holdoff();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'd0;
      if (pick == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 1000));
   endfunction

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         set_gain_limits(random_limit(), random_limit(), random_limit(), random_limit(),
                         random_limit(), random_limit(), random_holdoff());
         steady_flow = (phase == 2);
         send_random_replies(175);
      end
      steady_flow = 1'b0;
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : command_check
      velocity_cmd_type got;
      velocity_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_commands.size() == 0) begin
            mismatches++;
            $display("%0t ns: word expected none got %h", $time, got);
         end else begin
            want = expected_commands.pop_front();
            check_field("vel_forward", want.vel_forward, got.vel_forward);
            check_field("vel_side", want.vel_side, got.vel_side);
            check_field("vel_turn", want.vel_turn, got.vel_turn);
            check_field("reset_request", 16'(want.reset_request), 16'(got.reset_request));
            check_field("rumble_request", 16'(want.rumble_request), 16'(got.rumble_request));
            check_field("reply_valid", 16'(want.reply_valid), 16'(got.reply_valid));
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      clear_command_state();
      tick_now = 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_extremes();
      test_random_traffic();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_commands.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/gvc_pkg.sv
hdl/gamepad_velocity_command_top.sv
sim/gamepad_velocity_command_top_tb.sv
